// ===== sv/sgr_pkg.sv =====
// shared types and constants for the stream group reverser
package sgr_pkg;

   localparam int MAX_GROUP_DEF = 64;
   localparam int VAL_W = 32;
   localparam int GS_W = 7;
   localparam logic [GS_W-1:0] GROUP_SIZE_RESET = GS_W'(2);

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    end_of_list;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_value;
      logic                    run_last;
      logic                    list_last;
   } rsp_type;

   // command passed from the front to the back
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    eol;
      logic                    flush;
      logic                    rev;
   } cmd_type;

   // handshake pair of the command queue
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

// ===== sv/sgr_front.sv =====
// front end: beat acceptance, group size register and flush classification
module sgr_front #(
   parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sgr_pkg::req_type              req_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sgr_pkg::GS_W-1:0]      csr_data,
   output sgr_pkg::hs_type               push_hs_out,
   input  logic                          push_ready,
   output sgr_pkg::cmd_type              push_cmd
);
   import sgr_pkg::*;

   localparam int CW = $clog2(MAX_GROUP + 1);

   logic [GS_W-1:0] group_size_ff, group_size_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [GS_W-1:0] k_eff;
   logic [GS_W-1:0] n_ext;
   logic            accept;
   logic            flush_rev;
   logic            flush_fwd;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      priority if (group_size_ff == '0) begin
         k_eff = GS_W'(1);
      end else if (group_size_ff > GS_W'(MAX_GROUP)) begin
         k_eff = GS_W'(MAX_GROUP);
      end else begin
         k_eff = group_size_ff;
      end
   end

   assign n_ext     = GS_W'(fill_ff) + GS_W'(1);
   assign flush_rev = n_ext >= k_eff;
   assign flush_fwd = !flush_rev && req_data.end_of_list;

   assign push_hs_out.valid = req_valid;
   assign push_hs_out.ready = push_ready;
   assign push_cmd.value    = req_data.value;
   assign push_cmd.eol      = req_data.end_of_list;
   assign push_cmd.flush    = flush_rev || flush_fwd;
   assign push_cmd.rev      = flush_rev;

   always_comb begin
      group_size_in = group_size_ff;
      if (csr_valid) begin
         group_size_in = csr_data;
      end
      fill_in = fill_ff;
      if (accept) begin
         fill_in = (flush_rev || flush_fwd) ? '0 : fill_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= GROUP_SIZE_RESET;
         fill_ff       <= '0;
      end else begin
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
      end
   end

endmodule

// ===== sv/sgr_queue.sv =====
// two-entry command queue between front and back
module sgr_queue (
   input  logic             clock,
   input  logic             reset,
   input  sgr_pkg::hs_type  push_hs,
   output logic             push_ready,
   input  sgr_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sgr_pkg::cmd_type pop_cmd
);
   import sgr_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_cmd    = slot_ff[rptr_ff];
   assign do_push    = push_hs.valid && push_hs.ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/sgr_back.sv =====
// back end: group buffer, read-out sequencer and output stage
module sgr_back #(
   parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  sgr_pkg::cmd_type pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgr_pkg::rsp_type rsp_data
);
   import sgr_pkg::*;

   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic [VAL_W-1:0] buf_mem [MAX_GROUP];
   logic [VAL_W-1:0] rd_data_ff;

   logic          state_ff, state_in;
   logic [CW-1:0] wptr_ff, wptr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          rev_ff, rev_in;
   logic          eol_ff, eol_in;

   logic          a_valid_ff, a_valid_in;
   logic          a_run_ff, a_list_ff;
   logic          b_valid_ff, b_valid_in;
   rsp_type       b_data_ff;

   logic          do_pop;
   logic          rd_en;
   logic          b_load;
   logic          last_rd;

   assign pop_ready = state_ff == ST_IDLE;
   assign do_pop    = pop_valid && pop_ready;
   assign b_load    = a_valid_ff && (!b_valid_ff || rsp_ready);
   assign rd_en     = (state_ff == ST_READ) && (!a_valid_ff || b_load);
   assign last_rd   = rem_ff == CW'(1);

   assign rsp_valid = b_valid_ff;
   assign rsp_data  = b_data_ff;

   always_comb begin
      state_in = state_ff;
      wptr_in  = wptr_ff;
      rem_in   = rem_ff;
      raddr_in = raddr_ff;
      rev_in   = rev_ff;
      eol_in   = eol_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_pop) begin
               if (pop_cmd.flush) begin
                  state_in = ST_READ;
                  wptr_in  = '0;
                  rem_in   = wptr_ff + CW'(1);
                  raddr_in = pop_cmd.rev ? wptr_ff[AW-1:0] : '0;
                  rev_in   = pop_cmd.rev;
                  eol_in   = pop_cmd.eol;
               end else begin
                  wptr_in = wptr_ff + CW'(1);
               end
            end
         end
         ST_READ: begin
            if (rd_en) begin
               rem_in   = rem_ff - CW'(1);
               raddr_in = rev_ff ? raddr_ff - AW'(1) : raddr_ff + AW'(1);
               if (last_rd) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign a_valid_in = rd_en || (a_valid_ff && !b_load);
   assign b_valid_in = b_load || (b_valid_ff && !rsp_ready);

   // group buffer
   always_ff @(posedge clock) begin
      if (do_pop) begin
         buf_mem[wptr_ff[AW-1:0]] <= pop_cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[raddr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_run_ff  <= last_rd;
         a_list_ff <= last_rd && eol_ff;
      end
      if (b_load) begin
         b_data_ff.out_value <= rd_data_ff;
         b_data_ff.run_last  <= a_run_ff;
         b_data_ff.list_last <= a_list_ff;
      end
      raddr_ff <= raddr_in;
      rev_ff   <= rev_in;
      eol_ff   <= eol_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wptr_ff    <= '0;
         rem_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wptr_ff    <= wptr_in;
         rem_ff     <= rem_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

endmodule

// ===== sv/stream_group_reverser.sv =====
// top level of the stream group reverser
//
//   port group   dir   beat carries
//   req_*        in    one list value and its end-of-list flag
//   rsp_*        out   one reordered value with run and list end marks
//   csr_*        in    group size, always ready
//
// a beat passes the front combinationally into the queue, and the back writes it
// into the buffer; a flushed group of n values then streams out from the buffer
// read port at one beat per cycle while the output is not stalled
// the back takes no new command while a group is being read out
// reset is synchronous; the buffer needs no clearing pass
// either side may stall; the two-entry queue and output stage absorb it
module stream_group_reverser #(
   parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sgr_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sgr_pkg::rsp_type         rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [sgr_pkg::GS_W-1:0] csr_data
);
   import sgr_pkg::*;

   hs_type  push_hs;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   sgr_front #(
      .MAX_GROUP(MAX_GROUP)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .push_hs_out(push_hs),
      .push_ready(push_ready),
      .push_cmd(push_cmd)
   );

   sgr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_hs(push_hs),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd)
   );

   sgr_back #(
      .MAX_GROUP(MAX_GROUP)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== sv/sgr_checker.sv =====
// port-level checks for the stream group reverser, with bind
module sgr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sgr_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   import sgr_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a stalled request beat stays offered
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req beat withdrawn while stalled");

   // end of list always closes a run
   a_list_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.list_last |-> rsp_data.run_last)
      else $error("list_last without run_last");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // the group size register never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      $past(reset) == 1'b0 |-> csr_ready)
      else $error("csr port stalled");

endmodule

bind stream_group_reverser sgr_checker u_sgr_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data),
   .csr_ready(csr_ready)
);

// ===== tb/tb_stream_group_reverser.sv =====
// self-checking testbench for stream_group_reverser with its own reordering predictor
`timescale 1ns / 1ps

module tb_stream_group_reverser;
   import sgr_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int RST_CYC    = 10;
   localparam int SETTLE_CYC = 40;
   localparam int HOLD_CYC   = 400;
   localparam int IDLE_LIMIT = 3000;

   localparam int MODE_FLAT   = 0;
   localparam int MODE_TX_GAP = 1;
   localparam int MODE_RX_GAP = 2;
   localparam int MODE_BOTH   = 3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [GS_W-1:0]   csr_data = '0;

   req_type           list_q[$];
   rsp_type           reordered_q[$];

   logic [VAL_W-1:0]  grp_buf[MAX_GROUP_DEF];
   int                fill_cnt = 0;
   logic [GS_W-1:0]   gs_reg = GROUP_SIZE_RESET;

   int                idle_mode = MODE_FLAT;
   bit                hold_req = 1'b0;
   int                err_cnt = 0;
   int                beats_in = 0;
   int                beats_out = 0;
   int                gs_writes = 0;
   int                lists_sent = 0;
   int                longest_run = 0;
   int                idle_cyc = 0;

   stream_group_reverser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int eff_group(logic [GS_W-1:0] gs);
      if (gs == 0)
         return 1;
      if (gs > MAX_GROUP_DEF)
         return MAX_GROUP_DEF;
      return gs;
   endfunction

   // buffer the beat; on a full group or list end, queue the reordered run
   task automatic reorder_beat(input req_type b);
      int k;
      int n;
      rsp_type r;
      k = eff_group(gs_reg);
      if (fill_cnt < MAX_GROUP_DEF) begin
         grp_buf[fill_cnt] = b.value;
         fill_cnt++;
      end
      n = fill_cnt;
      if (n >= k || b.end_of_list) begin
         for (int i = 0; i < n; i++) begin
            r.out_value = (n >= k) ? grp_buf[n - 1 - i] : grp_buf[i];
            r.run_last  = (i == n - 1);
            r.list_last = (i == n - 1) && b.end_of_list;
            reordered_q.push_back(r);
         end
         if (n > longest_run)
            longest_run = n;
         fill_cnt = 0;
      end
   endtask

   always @(posedge clock) begin : drive_req
      bit fire;
      int gap_pct;
      fire = req_valid && req_ready;
      gap_pct = (idle_mode == MODE_TX_GAP) ? 63 : (idle_mode == MODE_BOTH) ? 30 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            reorder_beat(req_data);
            beats_in++;
         end
         if (!req_valid || fire) begin
            if (list_q.size() > 0 && !chance(gap_pct)) begin
               req_valid <= 1'b1;
               req_data  <= list_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      int hold_left;
      int stall_pct;
      rsp_type want;
      stall_pct = (idle_mode == MODE_RX_GAP) ? 63 : (idle_mode == MODE_BOTH) ? 30 : 0;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (reordered_q.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected result beat %h", $time, rsp_data);
            end else begin
               want = reordered_q.pop_front();
               if (rsp_data.out_value !== want.out_value) begin
                  err_cnt++;
                  $display("%0t: out_value expected %h actual %h",
                           $time, want.out_value, rsp_data.out_value);
               end
               if (rsp_data.run_last !== want.run_last) begin
                  err_cnt++;
                  $display("%0t: run_last expected %b actual %b",
                           $time, want.run_last, rsp_data.run_last);
               end
               if (rsp_data.list_last !== want.list_last) begin
                  err_cnt++;
                  $display("%0t: list_last expected %b actual %b",
                           $time, want.list_last, rsp_data.list_last);
               end
            end
         end
         if (hold_req) begin
            hold_left = HOLD_CYC;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !chance(stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("[stream_group_reverser] ERROR");
         $finish;
      end else begin
         idle_cyc <= idle_cyc + 1;
      end
   end

   task automatic push_beat(input logic [VAL_W-1:0] v, input logic eol);
      req_type b;
      b.value = v;
      b.end_of_list = eol;
      list_q.push_back(b);
      if (eol)
         lists_sent++;
   endtask

   task automatic settle();
      while (list_q.size() > 0 || req_valid || reordered_q.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_group_size(input logic [GS_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      gs_reg = v;
      gs_writes++;
      @(negedge clock);
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_lists(input int n_beats, input int k);
      int sent;
      int len;
      sent = 0;
      while (sent < n_beats) begin
         if (k > 16)
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : $urandom_range(k, k + 10);
         else
            len = $urandom_range(1, 3 * k);
         for (int i = 0; i < len; i++)
            push_beat(pick_value(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin : run_test
      int gs_plan[7];
      gs_plan = '{3, 1, 127, 8, 2, 64, 4};
      repeat (RST_CYC) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset group size of two: full groups, full group on the last beat, lone partial
      push_beat(32'h7FFF_FFFF, 1'b0);
      push_beat(32'h8000_0000, 1'b0);
      push_beat(32'hFFFF_FFFF, 1'b0);
      push_beat(32'h0000_0000, 1'b1);
      push_beat(32'h0000_0005, 1'b1);
      settle();
      // zero acts as one: straight through
      write_group_size('0);
      push_beat(32'h5555_5555, 1'b0);
      push_beat(32'hAAAA_AAAA, 1'b1);
      settle();
      // size lowered with a group part filled
      write_group_size(GS_W'(4));
      push_beat(32'h0000_0011, 1'b0);
      push_beat(32'h0000_0022, 1'b0);
      push_beat(32'h0000_0033, 1'b0);
      settle();
      write_group_size(GS_W'(2));
      push_beat(32'h0000_0044, 1'b0);
      settle();
      // list ends on a partial group
      write_group_size(GS_W'(5));
      push_beat(32'h0000_0101, 1'b0);
      push_beat(32'h0000_0202, 1'b0);
      push_beat(32'h0000_0303, 1'b1);
      settle();

      for (int p = 0; p < 7; p++) begin
         write_group_size(GS_W'(gs_plan[p]));
         idle_mode = p % 4;
         if (gs_plan[p] == 127) begin
            idle_mode = MODE_FLAT;
            hold_req = 1'b1;
         end
         queue_lists((eff_group(GS_W'(gs_plan[p])) > 16) ? 40 : 25,
                     eff_group(GS_W'(gs_plan[p])));
         settle();
      end
      idle_mode = MODE_FLAT;
      settle();

      $display("covered %0d list beats in %0d lists and %0d result beats", beats_in,
               lists_sent, beats_out);
      $display("%0d group size writes, longest run %0d beats, %0d mismatches", gs_writes,
               longest_run, err_cnt);
      if (err_cnt == 0) begin
         $display("[stream_group_reverser] OK");
      end else begin
         $display("[stream_group_reverser] ERROR");
      end
      $finish;
   end

endmodule
